// ===== design/cpfm_pkg.sv =====
// package: widths, register indexes, reset values and sequencer states
`timescale 1ns / 1ps
package cpfm_pkg;

  localparam int CapW      = 16;
  localparam int FreqW     = 32;
  localparam int CountW    = 17;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 32;
  localparam int StepW     = $clog2(FreqW);

  localparam logic [CfgIdxW-1:0] CFG_CLOCK_FREQ  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COUNTER_TOP = 1'b1;

  localparam logic [FreqW-1:0] CLOCK_FREQ_RST  = 32'd288000000;
  localparam logic [CapW-1:0]  COUNTER_TOP_RST = 16'hFFFF;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } cpfm_state_t;

endpackage

// ===== design/cpfm_if.sv =====
// valid/ready channel interfaces for captures and results
`timescale 1ns / 1ps
interface cpfm_in_if
  import cpfm_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] capture_value;

  modport source (output valid, output capture_value, input ready);
  modport sink   (input valid, input capture_value, output ready);
endinterface

interface cpfm_out_if
  import cpfm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FreqW-1:0]  frequency;
  logic [CountW-1:0] elapsed_count;

  modport source (output valid, output frequency, output elapsed_count, input ready);
  modport sink   (input valid, input frequency, input elapsed_count, output ready);
endinterface

// ===== design/cpfm_pair.sv =====
// saturates captures to the counter top and forms the wrap-corrected count
`timescale 1ns / 1ps
module cpfm_pair
  import cpfm_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic [CapW-1:0]   cap_raw,
  input  logic [CapW-1:0]   first_raw,
  input  logic [CapW-1:0]   counter_top,
  output logic [CapW-1:0]   cap_sat,
  output logic [CountW-1:0] count
);

  localparam int MaskW = (COUNTER_WIDTH < CapW) ? COUNTER_WIDTH : CapW;
  localparam logic [CapW-1:0] CntMask = CapW'(({(CapW+1){1'b0}} | (1 << MaskW)) - 1);

  logic [CapW-1:0] top;
  logic [CapW-1:0] cap_m;
  logic [CapW-1:0] first_sat;

  always_comb begin
    top       = (counter_top > CntMask) ? CntMask : counter_top;
    cap_m     = cap_raw & CntMask;
    cap_sat   = (cap_m > top) ? top : cap_m;
    first_sat = (first_raw > top) ? top : first_raw;
    if (cap_sat > first_sat) begin
      count = {1'b0, cap_sat} - {1'b0, first_sat};
    end else begin
      // counter wrapped: equal captures give one full period
      count = {1'b0, top} - {1'b0, first_sat} + {1'b0, cap_sat} + CountW'(1);
    end
  end

endmodule

// ===== design/cpfm_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cpfm_divider
  import cpfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FreqW-1:0]  dividend,
  input  logic [CountW-1:0] divisor,
  output logic              done,
  output logic [FreqW-1:0]  quotient
);

  logic [CountW-1:0] rem_r, rem_nxt;
  logic [FreqW-1:0]  quo_r, quo_nxt;
  logic [CountW-1:0] div_r, div_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CountW:0]   trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[FreqW-1]};
    ge       = trial >= {1'b0, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      step_nxt = StepW'(FreqW - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits are enough
      rem_nxt  = ge ? CountW'(trial - {1'b0, div_r}) : trial[CountW-1:0];
      quo_nxt  = {quo_r[FreqW-2:0], ge};
      step_nxt = step_r - StepW'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/capture_pair_frequency_meter_top.sv =====
// reciprocal frequency meter on pairs of counter captures
//
// in_if carries one captured counter value per transfer. Captures are paired:
// the first of a pair is stored and gives no result, the second gives the
// wrap-corrected elapsed count and frequency = clock_freq / count on out_if.
// cfg_we/cfg_index/cfg_wdata write clock_freq (index 0) and counter_top
// (index 1); a write lands at once, the divider keeps the dividend it started with.
// A first capture is stored and the block is ready again at once.
// A second capture has its result on out_if after these steps: the
// count is formed in the transfer cycle, the divider then forms the quotient
// one bit at a time, and the output register is then loaded with it.
// in_if.ready is low until that load.
// The result sits in an output register, so a new pair can start while it
// waits; if the receiver stalls and the register is still full when the
// next quotient is ready, the block holds in the divide state until it drains.
// Reset clears the pair state, the output valid and restores the register
// defaults (288 MHz clock, counter top 0xFFFF).
`timescale 1ns / 1ps
module capture_pair_frequency_meter_top
  import cpfm_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  cpfm_in_if.sink             in_if,
  cpfm_out_if.source          out_if,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cpfm_state_t       state_r, state_nxt;
  logic [FreqW-1:0]  clock_freq_r;
  logic [CapW-1:0]   counter_top_r;
  logic              second_pending_r, second_pending_nxt;
  logic [CapW-1:0]   first_r, first_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FreqW-1:0]  out_freq_r, out_freq_nxt;
  logic [CountW-1:0] out_count_r, out_count_nxt;

  logic              in_ready;
  logic              in_xfer;
  logic              div_start;
  logic              div_done;
  logic [FreqW-1:0]  div_quo;
  logic              load_out;
  logic [CapW-1:0]   cap_sat;
  logic [CountW-1:0] count;

  cpfm_pair #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_pair (
    .cap_raw     (in_if.capture_value),
    .first_raw   (first_r),
    .counter_top (counter_top_r),
    .cap_sat     (cap_sat),
    .count       (count)
  );

  cpfm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clock_freq_r),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    in_xfer   = in_ready && in_if.valid;
    div_start = in_xfer && second_pending_r;
    load_out  = (state_r == ST_DIV) && div_done && (!out_valid_r || out_if.ready);
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    second_pending_nxt = second_pending_r;
    first_nxt          = first_r;
    count_nxt          = count_r;
    out_valid_nxt      = out_valid_r;
    out_freq_nxt       = out_freq_r;
    out_count_nxt      = out_count_r;
    if (in_xfer) begin
      second_pending_nxt = !second_pending_r;
      if (!second_pending_r) begin
        first_nxt = cap_sat;
      end else begin
        count_nxt = count;
      end
    end
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_freq_nxt  = div_quo;
      out_count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    count_r     <= count_nxt;
    out_freq_r  <= out_freq_nxt;
    out_count_r <= out_count_nxt;
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      second_pending_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      second_pending_r <= second_pending_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_freq_r  <= CLOCK_FREQ_RST;
      counter_top_r <= COUNTER_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_FREQ:  clock_freq_r  <= cfg_wdata[FreqW-1:0];
        CFG_COUNTER_TOP: counter_top_r <= cfg_wdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.frequency     = out_freq_r;
  assign out_if.elapsed_count = out_count_r;

endmodule
